// ===== rtl/ell_tess_pkg.sv =====
// ----------------------------------------------------------------------------
// ell_tess_pkg
// Shared types, constants and fixed-point helpers of the ellipse tessellator.
// ----------------------------------------------------------------------------
package ell_tess_pkg;

  localparam int unsigned SEGMENTS_DEF = 64;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned RAD_W        = 15;
  localparam int unsigned TRIG_W       = 16;
  localparam int unsigned COLOR_W      = 32;
  localparam int unsigned PROD_W       = 32;
  localparam int unsigned PIPE_DEPTH   = 2;
  localparam int unsigned DRAIN_W      = 2;
  localparam int unsigned QUARTER      = 16384;
  localparam logic [RAD_W-1:0] RAD_MAX = 15'h7fff;

  localparam logic [63:0] A1 = 64'd1686629713;
  localparam logic [63:0] A3 = 64'd693598668;
  localparam logic [63:0] A5 = 64'd85569306;
  localparam logic [63:0] A7 = 64'd5026995;
  localparam logic [63:0] A9 = 64'd172272;

  localparam logic REQ_FILL    = 1'b0;
  localparam logic REQ_OUTLINE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic issue;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
  } dp_status_t;

  // Sine of a quarter-wave angle q/16384, rounded to Q1.15.
  function automatic logic signed [TRIG_W-1:0] quarter_sine(input logic [14:0] q);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] r;
    t   = {49'd0, q} << 16;
    t2  = (t * t) >> 30;
    acc = A9;
    acc = A7 - ((acc * t2) >> 30);
    acc = A5 - ((acc * t2) >> 30);
    acc = A3 - ((acc * t2) >> 30);
    acc = A1 - ((acc * t2) >> 30);
    s   = (acc * t) >> 30;
    r   = (s + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[TRIG_W-1:0];
  endfunction

  // Sine of a phase given in units of 1/65536 turn.
  function automatic logic signed [TRIG_W-1:0] phase_sine(input logic [31:0] phase);
    logic [1:0]  quad;
    logic [13:0] r;
    logic signed [TRIG_W-1:0] v;
    quad = phase[15:14];
    r    = phase[13:0];
    if (quad[0]) begin
      v = quarter_sine(15'd16384 - {1'b0, r});
    end else begin
      v = quarter_sine({1'b0, r});
    end
    return quad[1] ? -v : v;
  endfunction

  // Centre plus rounded scaled offset, saturated to the coordinate range.
  function automatic logic signed [COORD_W-1:0] place(
    input logic signed [COORD_W-1:0] c,
    input logic signed [PROD_W-1:0]  prod
  );
    logic signed [PROD_W:0] b;
    logic signed [17:0]     off;
    logic signed [18:0]     sum;
    logic signed [COORD_W-1:0] res;
    b   = 33'(prod) + 33'sd16384;
    off = 18'(b >>> 15);
    sum = 19'(c) + 19'(off);
    if (sum > 19'sd32767) begin
      res = 16'sh7fff;
    end else if (sum < -19'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = sum[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/ell_tess_ctrl.sv =====
// ----------------------------------------------------------------------------
// ell_tess_ctrl
// Controller: accepts requests, walks the point index and waits for the
// datapath pipeline to empty.
// ----------------------------------------------------------------------------
module ell_tess_ctrl #(
  parameter int unsigned SEGMENTS = ell_tess_pkg::SEGMENTS_DEF,
  parameter int unsigned IDX_W    = $clog2(SEGMENTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  ell_tess_pkg::dp_status_t status,
  output ell_tess_pkg::dp_cmd_t   cmd,
  output logic [IDX_W-1:0]        idx
);

  ell_tess_pkg::ctrl_state_t state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [ell_tess_pkg::DRAIN_W-1:0] drain_r, drain_nxt;

  assign busy      = (state_r != ell_tess_pkg::ST_IDLE);
  assign cmd.load  = start && !busy && !status.skip;
  assign cmd.issue = (state_r == ell_tess_pkg::ST_RUN);
  assign idx       = k_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    case (state_r)
      ell_tess_pkg::ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ell_tess_pkg::ST_RUN;
          k_nxt     = '0;
        end
      end
      ell_tess_pkg::ST_RUN: begin
        if (k_r == IDX_W'(SEGMENTS)) begin
          state_nxt = ell_tess_pkg::ST_DRAIN;
          drain_nxt = '0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ell_tess_pkg::ST_DRAIN: begin
        if (drain_r == ell_tess_pkg::DRAIN_W'(ell_tess_pkg::PIPE_DEPTH - 1)) begin
          state_nxt = ell_tess_pkg::ST_IDLE;
        end else begin
          drain_nxt = drain_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ell_tess_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ell_tess_pkg::ST_IDLE;
      k_r     <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ===== rtl/ell_tess_dp.sv =====
// ----------------------------------------------------------------------------
// ell_tess_dp
// Datapath: request registers, sine/cosine table, four radius multipliers
// and the vertex stage that assembles one primitive per point after the first.
// ----------------------------------------------------------------------------
module ell_tess_dp #(
  parameter int unsigned SEGMENTS = ell_tess_pkg::SEGMENTS_DEF,
  parameter int unsigned IDX_W    = $clog2(SEGMENTS + 1)
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  ell_tess_pkg::dp_cmd_t                      cmd,
  input  logic [IDX_W-1:0]                           idx,
  output ell_tess_pkg::dp_status_t                   status,
  input  logic                                       in_req_type,
  input  logic signed [ell_tess_pkg::COORD_W-1:0]    in_center_x,
  input  logic signed [ell_tess_pkg::COORD_W-1:0]    in_center_y,
  input  logic [ell_tess_pkg::RAD_W-1:0]             in_radius_x,
  input  logic [ell_tess_pkg::RAD_W-1:0]             in_radius_y,
  input  logic [ell_tess_pkg::RAD_W-1:0]             in_thickness,
  input  logic [ell_tess_pkg::COLOR_W-1:0]           in_color_rgba,
  output logic                                       out_valid,
  output logic signed [ell_tess_pkg::COORD_W-1:0]    out_px0,
  output logic signed [ell_tess_pkg::COORD_W-1:0]    out_py0,
  output logic signed [ell_tess_pkg::COORD_W-1:0]    out_px1,
  output logic signed [ell_tess_pkg::COORD_W-1:0]    out_py1,
  output logic signed [ell_tess_pkg::COORD_W-1:0]    out_px2,
  output logic signed [ell_tess_pkg::COORD_W-1:0]    out_py2,
  output logic signed [ell_tess_pkg::COORD_W-1:0]    out_px3,
  output logic signed [ell_tess_pkg::COORD_W-1:0]    out_py3,
  output logic [ell_tess_pkg::COLOR_W-1:0]           out_prim_color,
  output logic                                       out_last_prim
);

  localparam int unsigned CW = ell_tess_pkg::COORD_W;
  localparam int unsigned RW = ell_tess_pkg::RAD_W;
  localparam int unsigned TW = ell_tess_pkg::TRIG_W;
  localparam int unsigned PW = ell_tess_pkg::PROD_W;

  logic signed [TW-1:0] cos_tab [SEGMENTS+1];
  logic signed [TW-1:0] sin_tab [SEGMENTS+1];

  for (genvar k = 0; k <= SEGMENTS; k++) begin : g_tab
    localparam int unsigned KK = k % SEGMENTS;
    localparam int unsigned PH = (KK * 65536 + SEGMENTS / 2) / SEGMENTS;
    assign cos_tab[k] = ell_tess_pkg::phase_sine(32'(PH + ell_tess_pkg::QUARTER));
    assign sin_tab[k] = ell_tess_pkg::phase_sine(32'(PH));
  end

  // Request registers.
  logic                 mode_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic [RW-1:0]        rx_r, ry_r, orx_r, ory_r;
  logic [RW-1:0]        orx_nxt, ory_nxt;
  logic [RW:0]          sum_x, sum_y;
  logic [ell_tess_pkg::COLOR_W-1:0] col_r;

  assign status.skip = (in_req_type == ell_tess_pkg::REQ_OUTLINE) && (in_thickness == '0);

  assign sum_x   = {1'b0, in_radius_x} + {1'b0, in_thickness};
  assign sum_y   = {1'b0, in_radius_y} + {1'b0, in_thickness};
  assign orx_nxt = sum_x[RW] ? ell_tess_pkg::RAD_MAX : sum_x[RW-1:0];
  assign ory_nxt = sum_y[RW] ? ell_tess_pkg::RAD_MAX : sum_y[RW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_req_type;
      cx_r   <= in_center_x;
      cy_r   <= in_center_y;
      rx_r   <= in_radius_x;
      ry_r   <= in_radius_y;
      orx_r  <= orx_nxt;
      ory_r  <= ory_nxt;
      col_r  <= in_color_rgba;
    end
  end

  // Stage 1: table read.
  logic                 v1_r;
  logic [IDX_W-1:0]     k1_r;
  logic signed [TW-1:0] cos_r, sin_r;

  // Stage 2: products of inner and outer radii.
  logic                 v2_r;
  logic [IDX_W-1:0]     k2_r;
  logic signed [PW-1:0] pix_r, piy_r, pox_r, poy_r;
  logic signed [PW-1:0] pix_nxt, piy_nxt, pox_nxt, poy_nxt;

  assign pix_nxt = $signed({1'b0, rx_r})  * cos_r;
  assign piy_nxt = $signed({1'b0, ry_r})  * sin_r;
  assign pox_nxt = $signed({1'b0, orx_r}) * cos_r;
  assign poy_nxt = $signed({1'b0, ory_r}) * sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    k1_r  <= idx;
    cos_r <= cos_tab[idx];
    sin_r <= sin_tab[idx];
    k2_r  <= k1_r;
    pix_r <= pix_nxt;
    piy_r <= piy_nxt;
    pox_r <= pox_nxt;
    poy_r <= poy_nxt;
  end

  // Stage 3: new points, previous points and the output word.
  logic signed [CW-1:0] nix, niy, nox, noy;
  logic signed [CW-1:0] pin_x_r, pin_y_r, pout_x_r, pout_y_r;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [CW-1:0] out_px0_r, out_py0_r, out_px1_r, out_py1_r;
  logic signed [CW-1:0] out_px2_r, out_py2_r, out_px3_r, out_py3_r;
  logic [ell_tess_pkg::COLOR_W-1:0] out_prim_color_r;
  logic                 out_last_prim_r;

  assign nix = ell_tess_pkg::place(cx_r, pix_r);
  assign niy = ell_tess_pkg::place(cy_r, piy_r);
  assign nox = ell_tess_pkg::place(cx_r, pox_r);
  assign noy = ell_tess_pkg::place(cy_r, poy_r);

  assign out_valid_nxt = v2_r && (k2_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      pin_x_r  <= nix;
      pin_y_r  <= niy;
      pout_x_r <= nox;
      pout_y_r <= noy;
    end
    if (out_valid_nxt) begin
      if (mode_r == ell_tess_pkg::REQ_FILL) begin
        out_px0_r <= cx_r;
        out_py0_r <= cy_r;
        out_px1_r <= pin_x_r;
        out_py1_r <= pin_y_r;
      end else begin
        out_px0_r <= pin_x_r;
        out_py0_r <= pin_y_r;
        out_px1_r <= pout_x_r;
        out_py1_r <= pout_y_r;
      end
      out_px2_r        <= (mode_r == ell_tess_pkg::REQ_FILL) ? nix : nox;
      out_py2_r        <= (mode_r == ell_tess_pkg::REQ_FILL) ? niy : noy;
      out_px3_r        <= nix;
      out_py3_r        <= niy;
      out_prim_color_r <= col_r;
      out_last_prim_r  <= (k2_r == IDX_W'(SEGMENTS));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_px0        = out_px0_r;
  assign out_py0        = out_py0_r;
  assign out_px1        = out_px1_r;
  assign out_py1        = out_py1_r;
  assign out_px2        = out_px2_r;
  assign out_py2        = out_py2_r;
  assign out_px3        = out_px3_r;
  assign out_py3        = out_py3_r;
  assign out_prim_color = out_prim_color_r;
  assign out_last_prim  = out_last_prim_r;

endmodule

// ===== rtl/ellipse_tessellator_unit.sv =====
// ----------------------------------------------------------------------------
// ellipse_tessellator_unit
// Ellipse tessellator: turns one ellipse request into SEGMENTS primitives.
// ----------------------------------------------------------------------------
// A request word is taken at a clock edge where start is high and busy is
// low. Fill requests give a triangle fan around the centre, outline requests
// give a ring of quads between the radius and the radius plus thickness.
// An outline request with zero thickness is taken but gives no result, and
// busy stays low.
// Results leave on the out_ ports, each for exactly one cycle with out_valid
// high; the receiver cannot stall them. out_last_prim marks the final word.
// After acceptance the results follow at one result per cycle. A request
// occupies the block while one table point per cycle passes through a
// three-stage pipeline of table read, radius multiply, and round, offset
// and saturate, and one extra point closes the ring.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// all valid flags; request and payload registers keep their contents.
// ----------------------------------------------------------------------------
module ellipse_tessellator_unit #(
  parameter int unsigned SEGMENTS = ell_tess_pkg::SEGMENTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    in_req_type,
  input  logic signed [ell_tess_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [ell_tess_pkg::COORD_W-1:0] in_center_y,
  input  logic [ell_tess_pkg::RAD_W-1:0]          in_radius_x,
  input  logic [ell_tess_pkg::RAD_W-1:0]          in_radius_y,
  input  logic [ell_tess_pkg::RAD_W-1:0]          in_thickness,
  input  logic [ell_tess_pkg::COLOR_W-1:0]        in_color_rgba,
  output logic                                    out_valid,
  output logic signed [ell_tess_pkg::COORD_W-1:0] out_px0,
  output logic signed [ell_tess_pkg::COORD_W-1:0] out_py0,
  output logic signed [ell_tess_pkg::COORD_W-1:0] out_px1,
  output logic signed [ell_tess_pkg::COORD_W-1:0] out_py1,
  output logic signed [ell_tess_pkg::COORD_W-1:0] out_px2,
  output logic signed [ell_tess_pkg::COORD_W-1:0] out_py2,
  output logic signed [ell_tess_pkg::COORD_W-1:0] out_px3,
  output logic signed [ell_tess_pkg::COORD_W-1:0] out_py3,
  output logic [ell_tess_pkg::COLOR_W-1:0]        out_prim_color,
  output logic                                    out_last_prim
);

  localparam int unsigned IDX_W = $clog2(SEGMENTS + 1);

  ell_tess_pkg::dp_cmd_t    cmd;
  ell_tess_pkg::dp_status_t status;
  logic [IDX_W-1:0]         idx;

  ell_tess_ctrl #(
    .SEGMENTS (SEGMENTS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd),
    .idx    (idx)
  );

  ell_tess_dp #(
    .SEGMENTS (SEGMENTS),
    .IDX_W    (IDX_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .idx            (idx),
    .status         (status),
    .in_req_type    (in_req_type),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius_x    (in_radius_x),
    .in_radius_y    (in_radius_y),
    .in_thickness   (in_thickness),
    .in_color_rgba  (in_color_rgba),
    .out_valid      (out_valid),
    .out_px0        (out_px0),
    .out_py0        (out_py0),
    .out_px1        (out_px1),
    .out_py1        (out_py1),
    .out_px2        (out_px2),
    .out_py2        (out_py2),
    .out_px3        (out_px3),
    .out_py3        (out_py3),
    .out_prim_color (out_prim_color),
    .out_last_prim  (out_last_prim)
  );

endmodule

// ===== rtl/ell_tess_chk.sv =====
// ----------------------------------------------------------------------------
// ell_tess_chk
// Port-level checks of the ellipse tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module ell_tess_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 in_req_type,
  input logic [ell_tess_pkg::RAD_W-1:0]       in_thickness,
  input logic                                 out_valid,
  input logic                                 out_last_prim
);

  // A request that produces words keeps the block busy.
  ast_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !(in_req_type && (in_thickness == '0)) |=> busy)
    else $error("accepted request did not raise busy");

  // Words of one request leave back to back until the last one.
  ast_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_prim |=> out_valid)
    else $error("gap inside a result burst");

  // The last word is followed by a quiet cycle.
  ast_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_prim |=> !out_valid)
    else $error("word right after the last word");

  // Busy drops exactly when the last word appears.
  ast_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_last_prim)
    else $error("busy ended without the last word");

  // No word appears in the cycle after a request is taken.
  ast_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("word right after acceptance");

endmodule

bind ellipse_tessellator_unit ell_tess_chk u_ell_tess_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_req_type   (in_req_type),
  .in_thickness  (in_thickness),
  .out_valid     (out_valid),
  .out_last_prim (out_last_prim)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ellipse tessellator unit.
// ----------------------------------------------------------------------------
// Sends fill and outline requests through the start/busy handshake with
// random gaps. A built-in fixed-point model computes every primitive of each
// accepted request and keeps it in order. Each result word is then checked
// field by field against the oldest primitive still waiting. Directed corner
// requests and empty outlines come first, then a long run of random requests.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned COORD_W     = ell_tess_pkg::COORD_W;
  localparam int unsigned RAD_W       = ell_tess_pkg::RAD_W;
  localparam int unsigned COLOR_W     = ell_tess_pkg::COLOR_W;
  localparam logic        REQ_FILL    = ell_tess_pkg::REQ_FILL;
  localparam logic        REQ_OUTLINE = ell_tess_pkg::REQ_OUTLINE;

  localparam int SEG_N      = ell_tess_pkg::SEGMENTS_DEF;
  localparam int CYCLE_CAP  = 300000;
  localparam int TAIL_WAIT  = 20;
  localparam int RANDOM_REQ = 370;

  localparam longint SIN_C1 = 64'd1686629713;
  localparam longint SIN_C3 = 64'd693598668;
  localparam longint SIN_C5 = 64'd85569306;
  localparam longint SIN_C7 = 64'd5026995;
  localparam longint SIN_C9 = 64'd172272;

  typedef struct {
    logic                      kind;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          rx;
    logic [RAD_W-1:0]          ry;
    logic [RAD_W-1:0]          th;
    logic [COLOR_W-1:0]        rgba;
  } ellipse_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px0;
    logic signed [COORD_W-1:0] py0;
    logic signed [COORD_W-1:0] px1;
    logic signed [COORD_W-1:0] py1;
    logic signed [COORD_W-1:0] px2;
    logic signed [COORD_W-1:0] py2;
    logic signed [COORD_W-1:0] px3;
    logic signed [COORD_W-1:0] py3;
    logic [COLOR_W-1:0]        color;
    logic                      last_flag;
  } prim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = REQ_FILL;
  logic signed [COORD_W-1:0] in_center_x = '0;
  logic signed [COORD_W-1:0] in_center_y = '0;
  logic [RAD_W-1:0] in_radius_x = '0;
  logic [RAD_W-1:0] in_radius_y = '0;
  logic [RAD_W-1:0] in_thickness = '0;
  logic [COLOR_W-1:0] in_color_rgba = '0;
  logic out_valid;
  logic signed [COORD_W-1:0] out_px0, out_py0, out_px1, out_py1;
  logic signed [COORD_W-1:0] out_px2, out_py2, out_px3, out_py3;
  logic [COLOR_W-1:0] out_prim_color;
  logic out_last_prim;

  prim_t pending_prims[$];
  prim_t front_prim;
  int n_errors = 0;
  int n_checked = 0;
  int n_fill = 0;
  int n_outline = 0;
  int n_empty = 0;
  int cycle_count = 0;
  int gap_ceiling = 19;

  ellipse_tessellator_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius_x    (in_radius_x),
    .in_radius_y    (in_radius_y),
    .in_thickness   (in_thickness),
    .in_color_rgba  (in_color_rgba),
    .out_valid      (out_valid),
    .out_px0        (out_px0),
    .out_py0        (out_py0),
    .out_px1        (out_px1),
    .out_py1        (out_py1),
    .out_px2        (out_px2),
    .out_py2        (out_py2),
    .out_px3        (out_px3),
    .out_py3        (out_py3),
    .out_prim_color (out_prim_color),
    .out_last_prim  (out_last_prim)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Quarter-wave sine of q/16384, Q1.15, by the odd Q30 polynomial.
  function automatic int quarter_wave(input int q);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] r;
    t   = 64'(q) << 16;
    t2  = (t * t) >> 30;
    acc = SIN_C9;
    acc = SIN_C7 - ((acc * t2) >> 30);
    acc = SIN_C5 - ((acc * t2) >> 30);
    acc = SIN_C3 - ((acc * t2) >> 30);
    acc = SIN_C1 - ((acc * t2) >> 30);
    s   = (acc * t) >> 30;
    r   = (s + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return int'(r);
  endfunction

  function automatic logic signed [COORD_W-1:0] turn_sine(input logic [15:0] phase);
    int mag;
    if (phase[14]) begin
      mag = quarter_wave(16384 - int'(phase[13:0]));
    end else begin
      mag = quarter_wave(int'(phase[13:0]));
    end
    return phase[15] ? COORD_W'(-mag) : COORD_W'(mag);
  endfunction

  function automatic logic [15:0] angle_of(input int k);
    int kk;
    kk = k % SEG_N;
    return 16'((kk * 65536 + SEG_N / 2) / SEG_N);
  endfunction

  function automatic logic signed [COORD_W-1:0] vertex_coord(
    input logic signed [COORD_W-1:0] c,
    input int                        rad,
    input logic signed [COORD_W-1:0] trig
  );
    longint prod;
    longint sum;
    prod = longint'(rad) * longint'(trig) + 64'sd16384;
    sum  = longint'(c) + (prod >>> 15);
    if (sum > 32767) begin
      sum = 32767;
    end else if (sum < -32768) begin
      sum = -32768;
    end
    return COORD_W'(sum);
  endfunction

  task automatic predict_primitives(input ellipse_req_t r);
    int ox;
    int oy;
    logic [15:0] a1;
    logic [15:0] a2;
    logic signed [COORD_W-1:0] c1, s1, c2, s2;
    prim_t p;
    ox = int'(r.rx) + int'(r.th);
    oy = int'(r.ry) + int'(r.th);
    if (ox > 32767) begin
      ox = 32767;
    end
    if (oy > 32767) begin
      oy = 32767;
    end
    for (int i = 0; i < SEG_N; i++) begin
      a1 = angle_of(i);
      a2 = angle_of(i + 1);
      c1 = turn_sine(a1 + 16'd16384);
      s1 = turn_sine(a1);
      c2 = turn_sine(a2 + 16'd16384);
      s2 = turn_sine(a2);
      if (r.kind == REQ_FILL) begin
        p.px0 = r.cx;
        p.py0 = r.cy;
        p.px1 = vertex_coord(r.cx, r.rx, c1);
        p.py1 = vertex_coord(r.cy, r.ry, s1);
        p.px2 = vertex_coord(r.cx, r.rx, c2);
        p.py2 = vertex_coord(r.cy, r.ry, s2);
        p.px3 = p.px2;
        p.py3 = p.py2;
      end else begin
        p.px0 = vertex_coord(r.cx, r.rx, c1);
        p.py0 = vertex_coord(r.cy, r.ry, s1);
        p.px1 = vertex_coord(r.cx, ox, c1);
        p.py1 = vertex_coord(r.cy, oy, s1);
        p.px2 = vertex_coord(r.cx, ox, c2);
        p.py2 = vertex_coord(r.cy, oy, s2);
        p.px3 = vertex_coord(r.cx, r.rx, c2);
        p.py3 = vertex_coord(r.cy, r.ry, s2);
      end
      p.color     = r.rgba;
      p.last_flag = (i == SEG_N - 1);
      pending_prims = {pending_prims, p};
    end
  endtask

  function automatic ellipse_req_t make_req(
    input logic kind, input int cx, input int cy,
    input int rx, input int ry, input int th, input logic [COLOR_W-1:0] rgba
  );
    ellipse_req_t r;
    r.kind = kind;
    r.cx   = COORD_W'(cx);
    r.cy   = COORD_W'(cy);
    r.rx   = RAD_W'(rx);
    r.ry   = RAD_W'(ry);
    r.th   = RAD_W'(th);
    r.rgba = rgba;
    return r;
  endfunction

  task automatic send_request(input ellipse_req_t r);
    int gap;
    gap = $urandom_range(0, gap_ceiling);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= r.kind;
    in_center_x   <= r.cx;
    in_center_y   <= r.cy;
    in_radius_x   <= r.rx;
    in_radius_y   <= r.ry;
    in_thickness  <= r.th;
    in_color_rgba <= r.rgba;
    do @(posedge clk); while (busy);
    if (r.kind == REQ_OUTLINE && r.th == '0) begin
      n_empty++;
    end else begin
      if (r.kind == REQ_FILL) n_fill++;
      else n_outline++;
      predict_primitives(r);
    end
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return -32768;
      2: return int'($urandom_range(0, 255)) - 128;
      default: return int'($urandom & 32'hffff);
    endcase
  endfunction

  function automatic int rand_length();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return 0;
      2: return $urandom_range(1, 64);
      3: return $urandom_range(0, 2047);
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  task automatic test_directed_corners();
    gap_ceiling = 19;
    send_request(make_req(REQ_FILL, 0, 0, 0, 0, 0, 32'h0000_0000));
    send_request(make_req(REQ_FILL, 0, 0, 32767, 32767, 32767, 32'hffff_ffff));
    send_request(make_req(REQ_FILL, 32767, 32767, 32767, 32767, 0, 32'h1234_5678));
    send_request(make_req(REQ_FILL, -32768, -32768, 32767, 32767, 5, 32'h8765_4321));
    send_request(make_req(REQ_FILL, -1234, 4321, 0, 0, 77, 32'haaaa_5555));
    send_request(make_req(REQ_FILL, 100, -100, 32767, 0, 0, 32'h5555_aaaa));
    send_request(make_req(REQ_FILL, 0, 0, 1, 1, 0, 32'h0f0f_0f0f));
    send_request(make_req(REQ_OUTLINE, 0, 0, 500, 500, 0, 32'hdead_beef));
    send_request(make_req(REQ_OUTLINE, 16, -16, 40, 30, 1, 32'hf0f0_f0f0));
    send_request(make_req(REQ_OUTLINE, 0, 0, 32767, 32767, 32767, 32'hffff_0000));
    send_request(make_req(REQ_OUTLINE, -5, 5, 0, 0, 100, 32'h0000_ffff));
    send_request(make_req(REQ_OUTLINE, 32767, -32768, 1000, 1000, 1000, 32'h00ff_ff00));
    send_request(make_req(REQ_OUTLINE, -32768, 32767, 20000, 15000, 20000, 32'hff00_00ff));
  endtask

  task automatic test_empty_outlines();
    gap_ceiling = 0;
    for (int i = 0; i < 6; i++) begin
      send_request(make_req(REQ_OUTLINE, rand_coord(), rand_coord(), rand_length(),
                            rand_length(), 0, $urandom));
      send_request(make_req(i[0] ? REQ_OUTLINE : REQ_FILL, rand_coord(), rand_coord(),
                            rand_length(), rand_length(), $urandom_range(1, 32767),
                            $urandom));
    end
  endtask

  task automatic test_random_requests();
    int productive;
    ellipse_req_t r;
    productive = 0;
    while (productive < RANDOM_REQ) begin
      if (productive % 40 == 0) begin
        gap_ceiling = ($urandom_range(0, 2) == 0) ? 0 : 19;
      end
      r = make_req(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_length(),
                   rand_length(), rand_length(), $urandom);
      send_request(r);
      if (!(r.kind == REQ_OUTLINE && r.th == '0)) begin
        productive++;
      end
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_prims.size() == 0) begin
        $error("result word with no primitive pending");
        n_errors++;
      end else begin
        front_prim = pending_prims.pop_front();
        check_field("px0", front_prim.px0, out_px0);
        check_field("py0", front_prim.py0, out_py0);
        check_field("px1", front_prim.px1, out_px1);
        check_field("py1", front_prim.py1, out_py1);
        check_field("px2", front_prim.px2, out_px2);
        check_field("py2", front_prim.py2, out_py2);
        check_field("px3", front_prim.px3, out_px3);
        check_field("py3", front_prim.py3, out_py3);
        check_field("prim_color", front_prim.color, out_prim_color);
        check_field("last_prim", front_prim.last_flag, out_last_prim);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Run stopped after %0d cycles with %0d primitives outstanding.",
               cycle_count, pending_prims.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_empty_outlines();
    test_random_requests();
    start <= 1'b0;
    while (pending_prims.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    $display("Sent %0d fill and %0d outline requests plus %0d empty outlines.",
             n_fill, n_outline, n_empty);
    $display("Checked %0d primitive words, %0d field errors.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ell_tess_pkg.sv
rtl/ell_tess_ctrl.sv
rtl/ell_tess_dp.sv
rtl/ellipse_tessellator_unit.sv
rtl/ell_tess_chk.sv
bench/tb_top.sv
